// File: hw/rtl/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// shared types, constants and a helper function of the vertex transform
// ----------------------------------------------------------------------------
package vt4_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned FP_W      = 32;
  localparam int unsigned MANT_W    = 48;
  localparam int unsigned UNIT_LAT  = 3;              // mul and add latency
  localparam int unsigned PIPE_LAT  = 4 * UNIT_LAT;   // mul + three chained adds

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_3F80_0000, 64'h0,
    64'h3F80_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_3F80_0000,
    64'h0,                   64'h3F80_0000_0000_0000
  };

  typedef enum logic {
    OP_POINT  = 1'b0,
    OP_VECTOR = 1'b1
  } opcode_t;

  // unrounded result handed to the normalize / round unit
  typedef struct packed {
    logic               special;
    logic [31:0]        special_bits;
    logic               sign;
    logic signed [10:0] exp;    // biased exponent when mant[47] is the leading one
    logic [47:0]        mant;
  } unr_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/vt4_norm.sv
// ----------------------------------------------------------------------------
// vt4_norm
// two-stage normalize and round-to-nearest-even to binary32
// ----------------------------------------------------------------------------
module vt4_norm (
  input  logic          clk,
  input  logic          en,
  input  vt4_pkg::unr_t din,
  output logic [31:0]   dout
);

  // stage 1: leading zero count and left shift
  logic [5:0]         lz;
  logic               s1_special;
  logic [31:0]        s1_bits;
  logic               s1_sign;
  logic               s1_zero;
  logic signed [10:0] s1_exp;
  logic [47:0]        s1_mant;

  assign lz = vt4_pkg::lzc48(din.mant);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_special <= din.special;
      s1_bits    <= din.special_bits;
      s1_sign    <= din.sign;
      s1_zero    <= (din.mant == '0);
      s1_exp     <= din.exp - $signed({5'b0, lz});
      s1_mant    <= din.mant << lz;
    end
  end

  // stage 2: subnormal shift and rounding
  logic signed [10:0] rsh_full;
  logic [5:0]         rsh;
  logic [95:0]        wide;
  logic [47:0]        m2;
  logic [7:0]         efield;
  logic               guard;
  logic               sticky;
  logic               inc;
  logic [30:0]        mag;
  logic [31:0]        res;

  always_comb begin
    rsh_full = 11'sd1 - s1_exp;
    if (s1_exp <= 11'sd0) begin
      rsh    = (rsh_full > 11'sd48) ? 6'd48 : rsh_full[5:0];
      efield = 8'd0;
    end else begin
      rsh    = 6'd0;
      efield = s1_exp[7:0];
    end
    wide   = {s1_mant, 48'b0} >> rsh;
    m2     = wide[95:48];
    guard  = m2[23];
    sticky = (|m2[22:0]) | (|wide[47:0]);
    inc    = guard & (sticky | m2[24]);
    mag    = {efield, m2[46:24]} + {30'b0, inc};
    if (s1_special) begin
      res = s1_bits;
    end else if (s1_zero) begin
      res = {s1_sign, 31'b0};
    end else if (s1_exp >= 11'sd255) begin
      res = {s1_sign, 8'hFF, 23'b0};
    end else begin
      res = {s1_sign, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= res;
    end
  end

endmodule

// File: hw/rtl/vt4_fmul.sv
// ----------------------------------------------------------------------------
// vt4_fmul
// pipelined binary32 multiplier: registered unrounded product, then vt4_norm
// ----------------------------------------------------------------------------
module vt4_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [7:0]    ea, eb;
  logic [23:0]   ma, mb;
  logic          a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic          sgn;
  vt4_pkg::unr_t u, u_q;

  always_comb begin
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {(a[30:23] != 8'd0), a[22:0]};
    mb     = {(b[30:23] != 8'd0), b[22:0]};
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    sgn    = a[31] ^ b[31];
    u.sign = sgn;
    u.exp  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
    u.mant = 48'(ma * mb);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      u.special      = 1'b1;
      u.special_bits = vt4_pkg::FP_QNAN;
    end else if (a_inf || b_inf) begin
      u.special      = 1'b1;
      u.special_bits = {sgn, 8'hFF, 23'b0};
    end else begin
      u.special      = 1'b0;
      u.special_bits = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_q <= u;
    end
  end

  vt4_norm u_norm (
    .clk  (clk),
    .en   (en),
    .din  (u_q),
    .dout (p)
  );

endmodule

// File: hw/rtl/vt4_fadd.sv
// ----------------------------------------------------------------------------
// vt4_fadd
// pipelined binary32 adder: registered unrounded sum, then vt4_norm
// ----------------------------------------------------------------------------
module vt4_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  logic [31:0]   big, sml;
  logic [7:0]    eb_eff, es_eff, d;
  logic [4:0]    dcl;
  logic [26:0]   mbig, msml, al;
  logic [53:0]   wide;
  logic [27:0]   sum;
  logic          a_nan, b_nan, a_inf, b_inf;
  vt4_pkg::unr_t u, u_q;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d      = eb_eff - es_eff;
    dcl    = (d > 8'd31) ? 5'd31 : d[4:0];
    mbig   = {(big[30:23] != 8'd0), big[22:0], 3'b0};
    msml   = {(sml[30:23] != 8'd0), sml[22:0], 3'b0};
    wide   = {msml, 27'b0} >> dcl;
    al     = {wide[53:28], wide[27] | (|wide[26:0])};
    if (big[31] != sml[31]) begin
      sum = {1'b0, mbig} - {1'b0, al};
    end else begin
      sum = {1'b0, mbig} + {1'b0, al};
    end
    u.sign = (sum == '0) ? (a[31] & b[31]) : big[31];
    u.exp  = $signed({3'b0, eb_eff}) + 11'sd1;
    u.mant = {sum, 20'b0};
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      u.special      = 1'b1;
      u.special_bits = vt4_pkg::FP_QNAN;
    end else if (a_inf || b_inf) begin
      u.special      = 1'b1;
      u.special_bits = {(a_inf ? a[31] : b[31]), 8'hFF, 23'b0};
    end else begin
      u.special      = 1'b0;
      u.special_bits = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_q <= u;
    end
  end

  vt4_norm u_norm (
    .clk  (clk),
    .en   (en),
    .din  (u_q),
    .dout (s)
  );

endmodule

// File: hw/rtl/vt4_lane.sv
// ----------------------------------------------------------------------------
// vt4_lane
// one output component: four products and an ordered chain of three sums
// ----------------------------------------------------------------------------
module vt4_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] vec [4],
  input  logic [31:0] wt  [4],
  output logic [31:0] res
);

  localparam int unsigned L = vt4_pkg::UNIT_LAT;

  logic [31:0] prod [4];
  logic [31:0] s01, s012;
  logic [31:0] dly2 [L];
  logic [31:0] dly3 [2*L];

  for (genvar r = 0; r < 4; r++) begin : g_mul
    vt4_fmul u_mul (
      .clk (clk),
      .en  (en),
      .a   (vec[r]),
      .b   (wt[r]),
      .p   (prod[r])
    );
  end

  // hold the later products until their partial sum is ready
  always_ff @(posedge clk) begin
    if (en) begin
      dly2[0] <= prod[2];
      dly3[0] <= prod[3];
      for (int i = 1; i < L; i++) dly2[i] <= dly2[i-1];
      for (int i = 1; i < 2*L; i++) dly3[i] <= dly3[i-1];
    end
  end

  vt4_fadd u_add0 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]),     .s(s01));
  vt4_fadd u_add1 (.clk(clk), .en(en), .a(s01),     .b(dly2[L-1]),   .s(s012));
  vt4_fadd u_add2 (.clk(clk), .en(en), .a(s012),    .b(dly3[2*L-1]), .s(res));

endmodule

// File: hw/rtl/vertex_transform_4x4.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// binary32 4x4 matrix times vector, while not stalled one vector per cycle
// ----------------------------------------------------------------------------
// usage:
//   input stream: s_axis_tdata carries x, y, z, w (x lowest), s_axis_tuser the
//   opcode (0 point with implicit w of one, 1 full vector)
//   output stream: m_axis_tdata carries the transformed x, y, z, w (x lowest);
//   for a point the output w is one
//   config port: cfg_we writes cfg_data to matrix register cfg_index; use it
//   only while no word is in flight (unenforced); reset loads the identity matrix
//   throughput: one word per cycle while the output is not stalled, fully pipelined
//   datapath per output lane: a multiply, then three chained adds, then the
//   output register
//   each product and sum is rounded separately, round to nearest even, no fma
//   backpressure: an output register plus one skid word; while the receiver
//   stalls the pipe keeps running until the skid word fills, then the whole
//   pipe freezes and s_axis_tready drops
//   reset: clears the valid pipe, output and skid flags, and reloads the
//   identity matrix
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
  input  logic                       clk,
  input  logic                       rst,
  // config write port
  input  logic                       cfg_we,
  input  logic [vt4_pkg::IDX_W-1:0]  cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]  cfg_data,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [127:0]               s_axis_tdata,   // in_x, in_y, in_z, in_w
  input  logic                       s_axis_tuser,   // opcode
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [127:0]               m_axis_tdata    // out_x, out_y, out_z, out_w
);

  localparam int unsigned LAT = vt4_pkg::PIPE_LAT;

  // matrix registers
  logic [vt4_pkg::REG_W-1:0] mreg [vt4_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) mreg[i] <= vt4_pkg::REG_RESET[i];
    end else if (cfg_we) begin
      mreg[cfg_index] <= cfg_data;
    end
  end

  // pipe enable: stalls only when the skid word is occupied
  logic en;
  logic skid_valid;
  logic in_acc;

  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // input vector, w replaced by one for points
  logic [31:0] vec [4];

  assign vec[0] = s_axis_tdata[31:0];
  assign vec[1] = s_axis_tdata[63:32];
  assign vec[2] = s_axis_tdata[95:64];
  assign vec[3] = (vt4_pkg::opcode_t'(s_axis_tuser) == vt4_pkg::OP_VECTOR) ?
                  s_axis_tdata[127:96] : vt4_pkg::FP_ONE;

  // four lanes, one per output component
  logic [31:0] lane_res [4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [31:0] wt [4];
    for (genvar r = 0; r < 4; r++) begin : g_wt
      assign wt[r] = mreg[r*2 + j/2][(j%2)*32 +: 32];
    end
    vt4_lane u_lane (
      .clk (clk),
      .en  (en),
      .vec (vec),
      .wt  (wt),
      .res (lane_res[j])
    );
  end

  // valid and opcode tracking alongside the lanes
  logic [LAT-1:0] vpipe;
  logic [LAT-1:0] opipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opipe <= {opipe[LAT-2:0], s_axis_tuser};
    end
  end

  // merge the lanes into one output word
  logic [127:0] merged;
  logic         pipe_v;

  assign pipe_v = vpipe[LAT-1];
  assign merged = {(vt4_pkg::opcode_t'(opipe[LAT-1]) == vt4_pkg::OP_VECTOR) ?
                   lane_res[3] : vt4_pkg::FP_ONE,
                   lane_res[2], lane_res[1], lane_res[0]};

  // output register and skid word
  logic [127:0] skid_data;
  logic         out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_free) begin
          m_axis_tvalid <= 1'b1;
          skid_valid    <= 1'b0;
        end
      end else if (pipe_v) begin
        if (out_free) begin
          m_axis_tvalid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        m_axis_tdata <= skid_data;
      end
    end else if (pipe_v) begin
      if (out_free) begin
        m_axis_tdata <= merged;
      end else begin
        skid_data <= merged;
      end
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid word held without an output word");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid word filled while output was free");

  a_pipe_delivers: assert property (@(posedge clk) disable iff (rst)
    (pipe_v && en) |=> m_axis_tvalid)
    else $error("finished word dropped at pipe exit");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !skid_valid && vpipe == '0))
    else $error("control state not cleared by reset");

endmodule
